// ===== hdl/lkvc_pkg.sv =====
// shared types and constants for the lru key/value cache
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] data;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } result_t;

endpackage

// ===== hdl/lkvc_in_stage.sv =====
// input register holding the item under lookup
module lkvc_in_stage
  import lkvc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== hdl/lkvc_store.sv =====
// entry store: parallel key match, lru age ranks and replacement
module lkvc_store
  import lkvc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CAP_W-1:0] capacity,
  input  logic             update,
  input  item_t            item,
  output result_t          result
);

  logic signed [KEY_W-1:0] key_r   [ENTRIES];
  logic signed [VAL_W-1:0] value_r [ENTRIES];
  logic [RANK_W-1:0]       rank_r  [ENTRIES];
  logic [RANK_W-1:0]       rank_nxt[ENTRIES];
  logic [ENTRIES-1:0]      valid_r, valid_nxt;
  logic [CNT_W-1:0]        held_r, held_nxt;

  logic [ENTRIES-1:0]      hit_vec, victim_vec, free_vec, key_wr, val_wr;
  logic                    hit, full, is_put;
  logic signed [VAL_W-1:0] hit_value;
  logic signed [KEY_W-1:0] victim_key;
  logic [RANK_W-1:0]       hit_rank, held_m1;
  logic [CMP_W-1:0]        eff_cap;

  assign is_put  = (item.op == OP_PUT);
  assign held_m1 = RANK_W'(held_r - CNT_W'(1));
  assign free_vec = ~valid_r & (valid_r + ENTRIES'(1));

  // effective capacity, clamped to one and to the entry count
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  assign full = CMP_W'(held_r) >= eff_cap;

  always_comb begin
    hit_value  = '0;
    victim_key = '0;
    hit_rank   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == item.key);
      victim_vec[i] = valid_r[i] && (rank_r[i] == held_m1);
      hit_value  = hit_value  | (hit_vec[i]    ? value_r[i] : '0);
      hit_rank   = hit_rank   | (hit_vec[i]    ? rank_r[i]  : '0);
      victim_key = victim_key | (victim_vec[i] ? key_r[i]   : '0);
    end
  end

  assign hit = |hit_vec;

  always_comb begin
    result.found       = hit;
    result.data        = (hit && !is_put) ? hit_value : '0;
    result.evicted     = !hit && is_put && full && (|victim_vec);
    result.evicted_key = result.evicted ? victim_key : '0;
  end

  always_comb begin
    valid_nxt = valid_r;
    held_nxt  = held_r;
    key_wr    = '0;
    val_wr    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (update) begin
      if (hit) begin
        if (is_put) begin
          val_wr = hit_vec;
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && rank_r[i] < hit_rank) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end else if (is_put && full) begin
        key_wr = victim_vec;
        val_wr = victim_vec;
        for (int i = 0; i < ENTRIES; i++) begin
          if (victim_vec[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i] && rank_r[i] < held_m1) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end else if (is_put && (|free_vec)) begin
        key_wr    = free_vec;
        val_wr    = free_vec;
        valid_nxt = valid_r | free_vec;
        held_nxt  = held_r + CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_vec[i]) begin
            rank_nxt[i] = '0;
          end else if (valid_r[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      held_r  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      held_r  <= held_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (key_wr[i]) begin
        key_r[i] <= item.key;
      end
      if (val_wr[i]) begin
        value_r[i] <= item.value;
      end
    end
  end

endmodule

// ===== hdl/lkvc_out_stage.sv =====
// result register on the output channel
module lkvc_out_stage
  import lkvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign advance = out_ready || !valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== hdl/lru_key_value_cache_core.sv =====
// top level of the lru key/value cache
// Fully associative 16-entry key/value cache with least-recently-used
// replacement. One get or put is taken per clock cycle while out_ready
// allows; its result passes the input register, then the result register.
// The throughput of one item per cycle comes from the entry store, which
// compares all keys in parallel and updates the age ranks in the same cycle
// as the lookup. The capacity register (reset 16; zero acts as one, values
// above 16 act as 16) is written through the cfg port; the user must write
// it only while no item is in flight, as the block does not enforce this.
// The store is empty after reset and needs no clearing time.
module lru_key_value_cache_core
  import lkvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_op,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_found,
  output logic signed [VAL_W-1:0] out_data,
  output logic                    out_evicted,
  output logic signed [KEY_W-1:0] out_evicted_key,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data
);

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  item_t            in_item, item;
  logic             item_valid, advance;
  result_t          res, out_res;

  assign cfg_ready = 1'b1;

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_valid && cfg_ready) begin
      capacity_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  always_comb begin
    in_item.op    = in_op;
    in_item.key   = in_key;
    in_item.value = in_value;
  end

  lkvc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lkvc_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (capacity_r),
    .update   (item_valid && advance),
    .item     (item),
    .result   (res)
  );

  lkvc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_found       = out_res.found;
  assign out_data        = out_res.data;
  assign out_evicted     = out_res.evicted;
  assign out_evicted_key = out_res.evicted_key;

endmodule

// ===== hdl/lkvc_checker.sv =====
// port-level checks for the lru key/value cache, bound to the top level
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_found,
  input logic signed [VAL_W-1:0] out_data,
  input logic                    out_evicted,
  input logic signed [KEY_W-1:0] out_evicted_key
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_found)
      && $stable(out_evicted) && $stable(out_evicted_key))
    else $error("result changed while stalled");

  // eviction only on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_found)
    else $error("eviction reported on a hit");

  // returned data only on a hit without eviction
  a_data_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data != '0 |-> out_found && !out_evicted)
    else $error("data returned without a hit");

  // evicted key is zero unless an eviction happened
  a_ekey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
